// File: design/last_lines_ring_buffer_macros.svh
// assertion macros for the last lines ring buffer
`ifndef LAST_LINES_RING_BUFFER_MACROS_SVH
`define LAST_LINES_RING_BUFFER_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define LLRB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true out of reset
`define LLRB_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define LLRB_ASSERT(label, clk, rst_n, prop, msg)
`define LLRB_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// File: design/llrb_pkg.sv
// types, constants and helper functions of the last lines ring buffer
`default_nettype none

package llrb_pkg;

  localparam int unsigned BufSize  = 1024;
  localparam int unsigned AddrW    = $clog2(BufSize);
  localparam int unsigned LenW     = AddrW + 1;
  localparam int unsigned MaxLines = 16;
  localparam int unsigned SlotW    = $clog2(MaxLines);
  localparam int unsigned CountW   = 5;

  localparam logic [CountW-1:0] DefaultLines = CountW'(5);
  localparam logic [7:0]        NewlineCode  = 8'd10;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APP_WAIT,
    ST_RD_SLOT,
    ST_RD_EVAL,
    ST_RD_CHAR
  } state_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_valid;
    logic       line_end;
    logic       done_res;
  } out_item_t;

  // one line record of the slot ring
  typedef struct packed {
    logic [AddrW-1:0] start;
    logic [LenW-1:0]  len;
  } slot_rec_t;

  // number of slots in use by the ring, 1..MaxLines
  function automatic logic [CountW-1:0] active_lines(input logic [CountW-1:0] cnt);
    logic [CountW-1:0] res;
    if (cnt == '0) begin
      res = CountW'(1);
    end else if (cnt > CountW'(MaxLines)) begin
      res = CountW'(MaxLines);
    end else begin
      res = cnt;
    end
    return res;
  endfunction

  // following slot of the ring, wrapping at the active count
  function automatic logic [SlotW-1:0] next_slot(input logic [SlotW-1:0]  s,
                                                 input logic [CountW-1:0] act);
    logic [CountW-1:0] n;
    n = CountW'(s) + CountW'(1);
    return (n >= act) ? '0 : n[SlotW-1:0];
  endfunction

endpackage

`default_nettype wire

// File: design/llrb_if.sv
// valid/ready channel interfaces for input and result beats
`default_nettype none

interface llrb_in_if;
  logic               valid;
  logic               ready;
  llrb_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface llrb_out_if;
  logic                valid;
  logic                ready;
  llrb_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

// File: design/llrb_ram.sv
// simple dual port ram, one write port, one registered read port
`default_nettype none

module llrb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: design/last_lines_ring_buffer.sv
// top level: last lines ring buffer over a text store and a line record ring
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    operation, char_code
//   out_o    out  valid/ready    out_char, out_valid, line_end, done_res
//   cfg      in   cfg_we_i       cfg_data_i (line_count)
//
// an append that opens a line passes ST_APP_WAIT (line record read); others end in
// ST_IDLE. a read passes ST_RD_SLOT, ST_RD_EVAL and, for a text byte, ST_RD_CHAR;
// each skipped slot repeats ST_RD_SLOT and ST_RD_EVAL. both rams read through
// registered ports. one item is in work at a time; the result register lets the next
// item in while a beat waits. a full output register stalls a read in place.
// reset clears the control state only; the rams need no clearing pass.
`default_nettype none
`include "last_lines_ring_buffer_macros.svh"

module last_lines_ring_buffer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [llrb_pkg::CountW-1:0]   cfg_data_i,
  llrb_in_if.sink                       in_i,
  llrb_out_if.source                    out_o
);

  localparam int unsigned AddrW  = llrb_pkg::AddrW;
  localparam int unsigned LenW   = llrb_pkg::LenW;
  localparam int unsigned SlotW  = llrb_pkg::SlotW;
  localparam int unsigned CountW = llrb_pkg::CountW;
  localparam int unsigned RecW   = $bits(llrb_pkg::slot_rec_t);

  // control and line state
  llrb_pkg::state_e                state_q, state_d;
  logic [CountW-1:0]               count_q, count_d;
  logic [llrb_pkg::MaxLines-1:0]   used_q, used_d;
  logic [SlotW-1:0]                newest_q, newest_d;
  logic [AddrW-1:0]                wp_q, wp_d;
  logic [LenW-1:0]                 space_q, space_d;
  logic                            inside_q, inside_d;
  logic [SlotW-1:0]                rslot_q, rslot_d;
  logic [LenW-1:0]                 roff_q, roff_d;
  logic                            reading_q, reading_d;
  logic                            out_valid_q, out_valid_d;

  // payload registers
  logic [7:0]                      char_q, char_d;
  logic                            full_q, full_d;
  logic [AddrW-1:0]                cur_start_q, cur_start_d;
  logic [LenW-1:0]                 cur_len_q, cur_len_d;
  llrb_pkg::out_item_t             out_item_q;

  // ram ports
  logic                            store_we, store_re;
  logic [AddrW-1:0]                store_waddr, store_raddr;
  logic [7:0]                      store_wdata, store_rdata;
  logic                            slot_we, slot_re;
  logic [SlotW-1:0]                slot_waddr, slot_raddr;
  llrb_pkg::slot_rec_t             slot_wrec, slot_rec;
  logic [RecW-1:0]                 slot_rdata;

  // decoded terms
  logic [CountW-1:0]               act;
  logic                            in_accept;
  llrb_pkg::op_e                   op;
  logic                            is_nl;
  logic [SlotW-1:0]                app_s, app_f;
  logic [AddrW-1:0]                diff;
  logic                            slot_used, rd_has_char, rd_has_nl, rd_last;
  logic                            out_free, emit, out_load;
  llrb_pkg::out_item_t             emit_item;
  logic                            do_clear;
  logic [CountW-1:0]               clr_act;

  llrb_ram #(
    .Width (8),
    .Depth (llrb_pkg::BufSize)
  ) u_text_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (store_waddr),
    .wdata_i (store_wdata),
    .re_i    (store_re),
    .raddr_i (store_raddr),
    .rdata_o (store_rdata)
  );

  llrb_ram #(
    .Width (RecW),
    .Depth (llrb_pkg::MaxLines)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wrec),
    .re_i    (slot_re),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  // decode
  assign act         = llrb_pkg::active_lines(count_q);
  assign in_i.ready  = (state_q == llrb_pkg::ST_IDLE);
  assign in_accept   = in_i.valid && in_i.ready;
  assign op          = llrb_pkg::op_e'(in_i.item.operation);
  assign is_nl       = (in_i.item.char_code == llrb_pkg::NewlineCode);
  assign app_s       = llrb_pkg::next_slot(newest_q, act);
  assign app_f       = llrb_pkg::next_slot(app_s, act);
  assign slot_rec    = llrb_pkg::slot_rec_t'(slot_rdata);
  assign diff        = slot_rec.start - wp_q;
  assign slot_used   = used_q[rslot_q];
  assign rd_has_char = slot_used && (roff_q < slot_rec.len);
  assign rd_has_nl   = slot_used && (roff_q == slot_rec.len);
  assign rd_last     = (rslot_q == newest_q);
  assign out_free    = !out_valid_q || out_o.ready;
  assign out_load    = emit && out_free;

  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_item_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      llrb_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (op == llrb_pkg::OP_APPEND && !is_nl && !inside_q) begin
            state_d = llrb_pkg::ST_APP_WAIT;
          end else if (op == llrb_pkg::OP_READ) begin
            state_d = llrb_pkg::ST_RD_SLOT;
          end
        end
      end
      llrb_pkg::ST_APP_WAIT: state_d = llrb_pkg::ST_IDLE;
      llrb_pkg::ST_RD_SLOT:  state_d = llrb_pkg::ST_RD_EVAL;
      llrb_pkg::ST_RD_EVAL: begin
        if (rd_has_char) begin
          state_d = llrb_pkg::ST_RD_CHAR;
        end else if (rd_has_nl || rd_last) begin
          if (out_free) begin
            state_d = llrb_pkg::ST_IDLE;
          end
        end else begin
          state_d = llrb_pkg::ST_RD_SLOT;
        end
      end
      llrb_pkg::ST_RD_CHAR: begin
        if (out_free) begin
          state_d = llrb_pkg::ST_IDLE;
        end
      end
      default: state_d = llrb_pkg::ST_IDLE;
    endcase
  end

  // ram controls and result beat
  always_comb begin
    store_we    = 1'b0;
    store_waddr = wp_q;
    store_wdata = in_i.item.char_code;
    store_re    = 1'b0;
    store_raddr = AddrW'(slot_rec.start + roff_q[AddrW-1:0]);
    slot_we     = 1'b0;
    slot_waddr  = newest_q;
    slot_wrec   = '{start: cur_start_q, len: cur_len_q + LenW'(1)};
    slot_re     = 1'b0;
    slot_raddr  = rslot_q;
    emit        = 1'b0;
    emit_item   = '{out_char: store_rdata, out_valid: 1'b1, line_end: 1'b0,
                    done_res: 1'b0};
    case (state_q)
      llrb_pkg::ST_IDLE: begin
        if (in_accept && op == llrb_pkg::OP_APPEND && !is_nl) begin
          if (inside_q) begin
            store_we = (space_q != '0);
            slot_we  = (space_q != '0);
          end else begin
            slot_re    = 1'b1;
            slot_raddr = app_f;
          end
        end
      end
      llrb_pkg::ST_APP_WAIT: begin
        store_we    = 1'b1;
        store_wdata = char_q;
        slot_we     = 1'b1;
        slot_wrec   = '{start: wp_q, len: LenW'(1)};
      end
      llrb_pkg::ST_RD_SLOT: begin
        slot_re = 1'b1;
      end
      llrb_pkg::ST_RD_EVAL: begin
        if (rd_has_char) begin
          store_re = 1'b1;
        end else if (rd_has_nl) begin
          emit      = 1'b1;
          emit_item = '{out_char: llrb_pkg::NewlineCode, out_valid: 1'b1,
                        line_end: 1'b1, done_res: 1'b0};
        end else if (rd_last) begin
          emit      = 1'b1;
          emit_item = '{out_char: 8'd0, out_valid: 1'b0, line_end: 1'b0,
                        done_res: 1'b1};
        end
      end
      llrb_pkg::ST_RD_CHAR: begin
        emit = 1'b1;
      end
      default: ;
    endcase
  end

  // register next values
  always_comb begin
    count_d     = count_q;
    used_d      = used_q;
    newest_d    = newest_q;
    wp_d        = wp_q;
    space_d     = space_q;
    inside_d    = inside_q;
    rslot_d     = rslot_q;
    roff_d      = roff_q;
    reading_d   = reading_q;
    char_d      = char_q;
    full_d      = full_q;
    cur_start_d = cur_start_q;
    cur_len_d   = cur_len_q;
    do_clear    = 1'b0;
    clr_act     = act;
    out_valid_d = out_load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

    if (cfg_we_i) begin
      count_d  = cfg_data_i;
      clr_act  = llrb_pkg::active_lines(cfg_data_i);
      do_clear = 1'b1;
    end else begin
      case (state_q)
        llrb_pkg::ST_IDLE: begin
          if (in_accept) begin
            case (op)
              llrb_pkg::OP_APPEND: begin
                if (is_nl) begin
                  inside_d = 1'b0;
                end else if (inside_q) begin
                  if (space_q != '0) begin
                    wp_d      = wp_q + AddrW'(1);
                    space_d   = space_q - LenW'(1);
                    cur_len_d = cur_len_q + LenW'(1);
                  end
                end else begin
                  // new line takes the next slot and drops the oldest
                  newest_d      = app_s;
                  used_d[app_s] = 1'b1;
                  inside_d      = 1'b1;
                  char_d        = in_i.item.char_code;
                  full_d        = (app_f == app_s) || !used_q[app_f];
                end
              end
              llrb_pkg::OP_READ: begin
                if (!reading_q) begin
                  reading_d = 1'b1;
                  rslot_d   = llrb_pkg::next_slot(newest_q, act);
                  roff_d    = '0;
                end
              end
              llrb_pkg::OP_CLEAR: do_clear = 1'b1;
              default: ;
            endcase
          end
        end
        llrb_pkg::ST_APP_WAIT: begin
          // space runs up to the start of the following kept line
          if (full_q || diff == '0) begin
            space_d = LenW'(llrb_pkg::BufSize - 1);
          end else begin
            space_d = {1'b0, diff} - LenW'(1);
          end
          wp_d        = wp_q + AddrW'(1);
          cur_start_d = wp_q;
          cur_len_d   = LenW'(1);
        end
        llrb_pkg::ST_RD_EVAL: begin
          if (rd_has_char) begin
            roff_d = roff_q + LenW'(1);
          end else if (rd_has_nl) begin
            if (out_free) begin
              roff_d = roff_q + LenW'(1);
            end
          end else if (rd_last) begin
            if (out_free) begin
              reading_d = 1'b0;
              rslot_d   = '0;
              roff_d    = '0;
            end
          end else begin
            rslot_d = llrb_pkg::next_slot(rslot_q, act);
            roff_d  = '0;
          end
        end
        default: ;
      endcase
    end

    // clear all lines and the read session
    if (do_clear) begin
      used_d    = '0;
      newest_d  = SlotW'(clr_act - CountW'(1));
      wp_d      = '0;
      space_d   = '0;
      inside_d  = 1'b0;
      rslot_d   = '0;
      roff_d    = '0;
      reading_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= llrb_pkg::ST_IDLE;
      count_q     <= llrb_pkg::DefaultLines;
      used_q      <= '0;
      newest_q    <= SlotW'(llrb_pkg::DefaultLines - CountW'(1));
      wp_q        <= '0;
      space_q     <= '0;
      inside_q    <= 1'b0;
      rslot_q     <= '0;
      roff_q      <= '0;
      reading_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      used_q      <= used_d;
      newest_q    <= newest_d;
      wp_q        <= wp_d;
      space_q     <= space_d;
      inside_q    <= inside_d;
      rslot_q     <= rslot_d;
      roff_q      <= roff_d;
      reading_q   <= reading_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    char_q      <= char_d;
    full_q      <= full_d;
    cur_start_q <= cur_start_d;
    cur_len_q   <= cur_len_d;
    if (out_load) begin
      out_item_q <= emit_item;
    end
  end

  // checks
  `LLRB_ASSERT(a_newest_in_ring, clk_i, rst_ni, newest_q < act, "newest slot outside ring")
  `LLRB_ASSERT_NEVER(a_space_range, clk_i, rst_ni, space_q > LenW'(llrb_pkg::BufSize), "space too large")
  `LLRB_ASSERT(a_done_ends_read, clk_i, rst_ni, out_load && emit_item.done_res |=> !reading_q, "read session open after done")
  `LLRB_ASSERT(a_write_in_line, clk_i, rst_ni, store_we |=> inside_q, "text written outside a line")

endmodule

`default_nettype wire
